/* rtl/core/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and helpers for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned RawW     = 20;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_T1    = 3'd0,
    REG_T2    = 3'd1,
    REG_T3    = 3'd2,
    REG_P1    = 3'd3,
    REG_P23   = 3'd4,
    REG_P45   = 3'd5,
    REG_P67   = 3'd6,
    REG_P89   = 3'd7
  } cfg_reg_t;

  // calibration words, already sign-extended to 32 bits where signed
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
  } cal_t;

  // front end result handed to the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] num;
    logic [31:0] den;
  } front_t;

  // side data carried alongside the quotient
  typedef struct packed {
    logic [31:0] temp;
    logic        post_dbl;
    logic        zero;
  } side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    asr32 = $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    sx16 = {{16{x[15]}}, x};
  endfunction

endpackage

/* rtl/core/bsc_front.sv */
// ----------------------------------------------------------------------------
// bsc_front
// Ten-stage temperature and pressure polynomial pipeline up to the divide.
// ----------------------------------------------------------------------------
module bsc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [19:0]        raw_pressure,
  input  logic [19:0]        raw_temperature,
  input  bsc_pkg::cal_t      cal,
  output logic               out_valid,
  output bsc_pkg::front_t    out_data
);
  import bsc_pkg::*;

  logic [9:0]  vld;
  logic [19:0] adc_p [0:8];
  logic [31:0] s1_at, s1_d, s2_m1, s2_dd, s3_a, s3_m, s4_fine;
  logic [31:0] temp [5:9];
  logic [31:0] s5_pa, s6_q, s6_m5, s6_m2, s7_b6, s7_m3, s7_m5, s7_m2;
  logic [31:0] s8_b, s8_x, s9_b, s9_xm;
  logic [31:0] p_num, p_den, p_temp;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:0], in_valid};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      adc_p[0] <= raw_pressure;
      for (int i = 1; i < 9; i++) adc_p[i] <= adc_p[i-1];
      // stage 1: offsets from the reference temperature
      s1_at <= {15'd0, raw_temperature[19:3]} - {15'd0, cal.t1[15:0], 1'b0};
      s1_d  <= {16'd0, raw_temperature[19:4]} - cal.t1;
      // stage 2
      s2_m1 <= s1_at * cal.t2;
      s2_dd <= s1_d * s1_d;
      // stage 3
      s3_a  <= asr32(s2_m1, 11);
      s3_m  <= asr32(s2_dd, 12) * cal.t3;
      // stage 4: fine temperature
      s4_fine <= s3_a + asr32(s3_m, 14);
      // stage 5
      temp[5] <= asr32(s4_fine * 32'd5 + 32'd128, 8);
      s5_pa   <= asr32(s4_fine, 1) - 32'd64000;
      // stage 6
      temp[6] <= temp[5];
      s6_q    <= asr32(s5_pa, 2) * asr32(s5_pa, 2);
      s6_m5   <= s5_pa * cal.p5;
      s6_m2   <= cal.p2 * s5_pa;
      // stage 7
      temp[7] <= temp[6];
      s7_b6   <= asr32(s6_q, 11) * cal.p6;
      s7_m3   <= cal.p3 * asr32(s6_q, 13);
      s7_m5   <= s6_m5;
      s7_m2   <= s6_m2;
      // stage 8
      temp[8] <= temp[7];
      s8_b    <= asr32(s7_b6 + {s7_m5[30:0], 1'b0}, 2) + {cal.p4[15:0], 16'd0};
      s8_x    <= 32'd32768 + asr32(asr32(s7_m3, 3) + asr32(s7_m2, 1), 18);
      // stage 9
      temp[9] <= temp[8];
      s9_b    <= s8_b;
      s9_xm   <= s8_x * cal.p1;
      // stage 10: divisor and scaled numerator
      p_den   <= asr32(s9_xm, 15);
      p_num   <= ((32'd1048576 - {12'd0, adc_p[8]}) - asr32(s9_b, 12)) * 32'd3125;
      p_temp  <= temp[9];
    end
  end

  assign out_data.temp = p_temp;
  assign out_data.num  = p_num;
  assign out_data.den  = p_den;
  assign out_valid     = vld[9];

endmodule

/* rtl/core/bsc_div.sv */
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  bsc_pkg::front_t    in_data,
  output logic               out_valid,
  output logic [31:0]        quot,
  output bsc_pkg::side_t     out_side
);
  import bsc_pkg::*;

  logic [DivSteps-1:0] vld;
  logic [31:0] rem  [0:DivSteps-1];
  logic [31:0] numr [0:DivSteps-1];
  logic [31:0] quo  [0:DivSteps-1];
  logic [31:0] den  [0:DivSteps-1];
  side_t       side [0:DivSteps-1];

  logic [31:0] rem_n  [0:DivSteps-1];
  logic [31:0] numr_n [0:DivSteps-1];
  logic [31:0] quo_n  [0:DivSteps-1];
  logic [31:0] den_n  [0:DivSteps-1];
  side_t       side_n [0:DivSteps-1];

  // one shift-subtract step per stage; first stage loads the operands
  always_comb begin
    logic [31:0] r, n, q, d;
    logic [32:0] t;
    for (int k = 0; k < DivSteps; k++) begin
      if (k == 0) begin
        r = '0;
        q = '0;
        d = in_data.den;
        n = in_data.num[31] ? in_data.num : {in_data.num[30:0], 1'b0};
        side_n[k].temp     = in_data.temp;
        side_n[k].post_dbl = in_data.num[31];
        side_n[k].zero     = (in_data.den == '0);
      end else begin
        r = rem[k-1];
        n = numr[k-1];
        q = quo[k-1];
        d = den[k-1];
        side_n[k] = side[k-1];
      end
      t = {r, n[31]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
      rem_n[k]  = t[31:0];
      numr_n[k] = {n[30:0], 1'b0};
      quo_n[k]  = q;
      den_n[k]  = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DivSteps-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DivSteps; k++) begin
        rem[k]  <= rem_n[k];
        numr[k] <= numr_n[k];
        quo[k]  <= quo_n[k];
        den[k]  <= den_n[k];
        side[k] <= side_n[k];
      end
    end
  end

  // large numerators were divided unshifted; double afterwards
  assign quot      = side[DivSteps-1].post_dbl ? {quo[DivSteps-1][30:0], 1'b0}
                                               : quo[DivSteps-1];
  assign out_side  = side[DivSteps-1];
  assign out_valid = vld[DivSteps-1];

endmodule

/* rtl/core/barometric_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// 32-bit integer temperature and pressure compensation of raw readings.
// ----------------------------------------------------------------------------
// Stages: 10 polynomial stages, 32 divider stages, 2 correction stages,
//   1 output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output
//   beat waits.
// Reset: rst clears all valid bits and calibration words to zero.
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // temperature_centi[31:0], pressure_pa[63:32]
  output logic [0:0]  m_tuser,   // divisor_zero[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bsc_pkg::*;

  logic [15:0] t1, t2, t3, p1;
  logic [31:0] p23, p45, p67, p89;
  cal_t        cal;
  logic        en;
  logic        f_valid, d_valid;
  front_t      f_data;
  logic [31:0] quot;
  side_t       d_side;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0; t2 <= '0; t3 <= '0; p1 <= '0;
      p23 <= '0; p45 <= '0; p67 <= '0; p89 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_T1:  t1  <= cfg_data[15:0];
        REG_T2:  t2  <= cfg_data[15:0];
        REG_T3:  t3  <= cfg_data[15:0];
        REG_P1:  p1  <= cfg_data[15:0];
        REG_P23: p23 <= cfg_data;
        REG_P45: p45 <= cfg_data;
        REG_P67: p67 <= cfg_data;
        REG_P89: p89 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = {16'd0, t1};
    cal.t2 = sx16(t2);
    cal.t3 = sx16(t3);
    cal.p1 = {16'd0, p1};
    cal.p2 = sx16(p23[15:0]);
    cal.p3 = sx16(p23[31:16]);
    cal.p4 = sx16(p45[15:0]);
    cal.p5 = sx16(p45[31:16]);
    cal.p6 = sx16(p67[15:0]);
    cal.p7 = sx16(p67[31:16]);
    cal.p8 = sx16(p89[15:0]);
    cal.p9 = sx16(p89[31:16]);
  end

  // global advance: move whenever the output register can take a beat
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  bsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (s_tvalid),
    .raw_pressure    (s_tdata[19:0]),
    .raw_temperature (s_tdata[39:20]),
    .cal             (cal),
    .out_valid       (f_valid),
    .out_data        (f_data)
  );

  bsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (d_valid),
    .quot      (quot),
    .out_side  (d_side)
  );

  // final correction stages
  logic [1:0]  c_vld;
  logic [31:0] c1_q, c1_ma, c1_mb, c2_q, c2_a, c2_b;
  side_t       c1_side, c2_side;
  logic [31:0] corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld    <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      c_vld    <= {c_vld[0], d_valid};
      m_tvalid <= c_vld[1];
    end
  end

  assign corr = c2_q + asr32(c2_a + c2_b + cal.p7, 4);

  always_ff @(posedge clk) begin
    if (en) begin
      c1_q    <= quot;
      c1_side <= d_side;
      c1_ma   <= {3'd0, quot[31:3]} * {3'd0, quot[31:3]};
      c1_mb   <= {2'd0, quot[31:2]} * cal.p8;
      c2_q    <= c1_q;
      c2_side <= c1_side;
      c2_a    <= asr32(cal.p9 * {13'd0, c1_ma[31:13]}, 12);
      c2_b    <= asr32(c1_mb, 13);
      m_tdata[31:0]  <= c2_side.temp;
      m_tdata[63:32] <= c2_side.zero ? 32'd0 : corr;
      m_tuser[0]     <= c2_side.zero;
    end
  end

`ifndef SYNTHESIS
  a_zero_pres: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[63:32] == 32'd0))
    else $error("pressure not zero with zero divisor");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output beat changed");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
